/* sv/stroked_rect_strip_gen_macros.svh */
// ---------------------------------------------------------------------------
// Stroked rectangle strip generator assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef STROKED_RECT_STRIP_GEN_MACROS_SVH
`define STROKED_RECT_STRIP_GEN_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srsg assertion failed");

// next-cycle implication, disabled in reset
`define SRSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srsg assertion failed");

`endif

/* sv/srsg_pkg.sv */
// ---------------------------------------------------------------------------
// srsg_pkg
// Types, constants and the strip table of the stroked rectangle generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package srsg_pkg;

    localparam int EDGE_W   = 32;
    localparam int WIDTH_W  = 31;
    localparam int HALF_W   = 30;
    localparam int EXT_W    = 33;
    localparam int LIMIT_W  = 16;
    localparam int VNUM_W   = 5;
    localparam int IDX_W    = 6;
    localparam int TABLE_N  = 39;

    localparam logic [LIMIT_W-1:0] SQRT2_Q8 = 16'd363;

    localparam logic JOIN_MITER = 1'b0;
    localparam logic JOIN_BEVEL = 1'b1;

    // selector codes: low edge / high edge, minus / none / plus half width
    localparam logic [2:0] SEL_LM = 3'd0;
    localparam logic [2:0] SEL_L  = 3'd1;
    localparam logic [2:0] SEL_LP = 3'd2;
    localparam logic [2:0] SEL_HM = 3'd3;
    localparam logic [2:0] SEL_H  = 3'd4;
    localparam logic [2:0] SEL_HP = 3'd5;

    localparam logic [IDX_W-1:0]  START_MITER_FILL  = 6'd0;
    localparam logic [IDX_W-1:0]  START_MITER_HOLL  = 6'd4;
    localparam logic [IDX_W-1:0]  START_BEVEL_FILL  = 6'd14;
    localparam logic [IDX_W-1:0]  START_BEVEL_HOLL  = 6'd22;
    localparam logic [VNUM_W-1:0] LAST_MITER_FILL   = 5'd3;
    localparam logic [VNUM_W-1:0] LAST_MITER_HOLL   = 5'd9;
    localparam logic [VNUM_W-1:0] LAST_BEVEL_FILL   = 5'd7;
    localparam logic [VNUM_W-1:0] LAST_BEVEL_HOLL   = 5'd16;

    typedef struct packed {
        logic [2:0] xs;
        logic [2:0] ys;
    } t_vsel;

    localparam t_vsel STRIP_TABLE [TABLE_N] = '{
        '{SEL_LM, SEL_LM}, '{SEL_HP, SEL_LM}, '{SEL_LM, SEL_HP}, '{SEL_HP, SEL_HP},
        '{SEL_LM, SEL_LM}, '{SEL_LP, SEL_LP}, '{SEL_HP, SEL_LM}, '{SEL_HM, SEL_LP},
        '{SEL_HP, SEL_HP}, '{SEL_HM, SEL_HM}, '{SEL_LM, SEL_HP}, '{SEL_LP, SEL_HM},
        '{SEL_LM, SEL_LM}, '{SEL_LP, SEL_LP},
        '{SEL_L,  SEL_LM}, '{SEL_H,  SEL_LM}, '{SEL_LM, SEL_L }, '{SEL_HP, SEL_L },
        '{SEL_LM, SEL_H }, '{SEL_HP, SEL_H }, '{SEL_L,  SEL_HP}, '{SEL_H,  SEL_HP},
        '{SEL_LM, SEL_L }, '{SEL_LP, SEL_LP}, '{SEL_L,  SEL_LM}, '{SEL_HM, SEL_LP},
        '{SEL_H,  SEL_LM}, '{SEL_HM, SEL_LP}, '{SEL_HP, SEL_L }, '{SEL_HM, SEL_HM},
        '{SEL_HP, SEL_H }, '{SEL_HM, SEL_HM}, '{SEL_H,  SEL_HP}, '{SEL_LP, SEL_HM},
        '{SEL_L,  SEL_HP}, '{SEL_LP, SEL_HM}, '{SEL_LM, SEL_H }, '{SEL_LP, SEL_LP},
        '{SEL_LM, SEL_L }
    };

    // front stage contents
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic [WIDTH_W-1:0]       width;
        logic signed [EXT_W-1:0]  ext_w;
        logic signed [EXT_W-1:0]  ext_h;
        logic                     bevel;
    } t_front;

    // classified item handed to the back end
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic [HALF_W-1:0]        half;
        logic                     bevel;
        logic                     filled;
    } t_desc;

endpackage
`default_nettype wire

/* sv/srsg_front.sv */
// ---------------------------------------------------------------------------
// srsg_front
// Accept items, drop negative or unscaled strokes, clamp width, classify fill.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module srsg_front
    import srsg_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [EDGE_W-1:0]  i_rect_left,
    input  wire logic signed [EDGE_W-1:0]  i_rect_top,
    input  wire logic signed [EDGE_W-1:0]  i_rect_right,
    input  wire logic signed [EDGE_W-1:0]  i_rect_bottom,
    input  wire logic signed [EDGE_W-1:0]  i_stroke_width,
    input  wire logic [WIDTH_W-1:0]        i_min_stroke_width,
    input  wire logic                      i_scale_valid,
    input  wire logic                      i_join_style,
    input  wire logic [LIMIT_W-1:0]        i_miter_limit,
    output logic                           o_push,
    output t_desc                          o_desc,
    input  wire logic                      i_q_ready
);

    logic   r_valid;
    t_front r_item;
    t_front n_item;
    logic   n_drop;
    logic   n_accept;

    always_comb begin
        n_drop         = i_stroke_width[EDGE_W-1] | ~i_scale_valid;
        n_item.left    = i_rect_left;
        n_item.top     = i_rect_top;
        n_item.right   = i_rect_right;
        n_item.bottom  = i_rect_bottom;
        n_item.width   = (i_stroke_width[WIDTH_W-1:0] > i_min_stroke_width)
                         ? i_stroke_width[WIDTH_W-1:0] : i_min_stroke_width;
        n_item.ext_w   = EXT_W'(i_rect_right) - EXT_W'(i_rect_left);
        n_item.ext_h   = EXT_W'(i_rect_bottom) - EXT_W'(i_rect_top);
        n_item.bevel   = (i_join_style == JOIN_BEVEL) || (i_miter_limit < SQRT2_Q8);
    end

    assign o_ready  = !r_valid || i_q_ready;
    assign n_accept = i_valid && o_ready;
    assign o_push   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_accept && !n_drop) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept && !n_drop) begin
            r_item <= n_item;
        end
    end

    // width >= min(ext_w, ext_h) split into two parallel compares
    always_comb begin
        o_desc.left   = r_item.left;
        o_desc.top    = r_item.top;
        o_desc.right  = r_item.right;
        o_desc.bottom = r_item.bottom;
        o_desc.half   = r_item.width[WIDTH_W-1:1];
        o_desc.bevel  = r_item.bevel;
        o_desc.filled = ($signed({2'b00, r_item.width}) >= r_item.ext_w)
                     || ($signed({2'b00, r_item.width}) >= r_item.ext_h);
    end

endmodule
`default_nettype wire

/* sv/srsg_queue.sv */
// ---------------------------------------------------------------------------
// srsg_queue
// Two-entry queue of classified items between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module srsg_queue
    import srsg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_ready,
    output logic       o_valid,
    output t_desc      o_desc,
    input  wire logic  i_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             n_wr;
    logic             n_rd;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign n_wr    = i_push && o_ready;
    assign n_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (n_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (n_wr && !n_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (n_rd && !n_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule
`default_nettype wire

/* sv/srsg_back.sv */
// ---------------------------------------------------------------------------
// srsg_back
// Step through the strip table and emit one saturated vertex per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module srsg_back
    import srsg_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire t_desc                    i_q_desc,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [EDGE_W-1:0]      o_vertex_x,
    output logic signed [EDGE_W-1:0]      o_vertex_y,
    output logic [VNUM_W-1:0]             o_vertex_number,
    output logic                          o_last_vertex
);

    localparam int SUM_W  = EDGE_W + 2;
    localparam int CW_EFF = (COORD_WIDTH < SUM_W) ? COORD_WIDTH : SUM_W;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        (SUM_W'(1) << (CW_EFF - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic signed [EDGE_W-1:0] coord_pick(
        input logic [2:0]               code,
        input logic signed [EDGE_W-1:0] lo,
        input logic signed [EDGE_W-1:0] hi,
        input logic [HALF_W-1:0]        half
    );
        logic signed [SUM_W-1:0] base;
        logic signed [SUM_W-1:0] h;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] sat;
        base = (code == SEL_LM || code == SEL_L || code == SEL_LP)
               ? SUM_W'(lo) : SUM_W'(hi);
        h    = SUM_W'(half);
        case (code)
            SEL_LM, SEL_HM: sum = base - h;
            SEL_LP, SEL_HP: sum = base + h;
            default:        sum = base;
        endcase
        if (sum > SAT_HI) begin
            sat = SAT_HI;
        end else if (sum < SAT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = sum;
        end
        return sat[EDGE_W-1:0];
    endfunction

    logic              r_busy;
    t_desc             r_desc;
    logic [IDX_W-1:0]  r_start;
    logic [VNUM_W-1:0] r_last;
    logic [VNUM_W-1:0] r_k;
    logic              r_out_valid;
    logic signed [EDGE_W-1:0] r_out_x;
    logic signed [EDGE_W-1:0] r_out_y;
    logic [VNUM_W-1:0] r_out_num;
    logic              r_out_last;

    logic              n_advance;
    logic              n_at_last;
    logic              n_pop;
    t_vsel             n_sel;
    logic [IDX_W-1:0]  n_start;
    logic [VNUM_W-1:0] n_last;
    logic signed [EDGE_W-1:0] n_x;
    logic signed [EDGE_W-1:0] n_y;

    always_comb begin
        n_advance = r_busy && (!r_out_valid || i_ready);
        n_at_last = (r_k == r_last);
        n_pop     = i_q_valid && (!r_busy || (n_advance && n_at_last));
        n_sel     = STRIP_TABLE[r_start + IDX_W'(r_k)];
        n_x       = coord_pick(n_sel.xs, r_desc.left, r_desc.right, r_desc.half);
        n_y       = coord_pick(n_sel.ys, r_desc.top, r_desc.bottom, r_desc.half);
        case ({i_q_desc.bevel, i_q_desc.filled})
            2'b00:   begin n_start = START_MITER_HOLL; n_last = LAST_MITER_HOLL; end
            2'b01:   begin n_start = START_MITER_FILL; n_last = LAST_MITER_FILL; end
            2'b10:   begin n_start = START_BEVEL_HOLL; n_last = LAST_BEVEL_HOLL; end
            default: begin n_start = START_BEVEL_FILL; n_last = LAST_BEVEL_FILL; end
        endcase
    end

    assign o_q_pop = n_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_pop) begin
                r_busy <= 1'b1;
            end else if (n_advance && n_at_last) begin
                r_busy <= 1'b0;
            end
            if (n_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_pop) begin
            r_desc  <= i_q_desc;
            r_start <= n_start;
            r_last  <= n_last;
            r_k     <= '0;
        end else if (n_advance) begin
            r_k <= r_k + VNUM_W'(1);
        end
        if (n_advance) begin
            r_out_x    <= n_x;
            r_out_y    <= n_y;
            r_out_num  <= r_k;
            r_out_last <= n_at_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_vertex_x      = r_out_x;
    assign o_vertex_y      = r_out_y;
    assign o_vertex_number = r_out_num;
    assign o_last_vertex   = r_out_last;

endmodule
`default_nettype wire

/* sv/stroked_rect_strip_gen.sv */
// One stroked rectangle per input item turns into a triangle strip of 4 or
// 10 vertices (miter join) or 8 or 17 vertices (bevel join, or miter with a
// limit below root two), one vertex per cycle unless the output stalls,
// last one flagged. An item with a negative stroke width or an invalid
// scale is taken and gives no vertices. The back-end vertex sequencer sets
// the rate, with no gap between queued items. An item passes the front
// register, the queue and the sequencer item register, its vertices the
// output register. A two-entry queue lets the front end keep taking items
// while the output stalls. Coordinates saturate to COORD_WIDTH signed bits.
// ---------------------------------------------------------------------------
// stroked_rect_strip_gen
// Stroked rectangle to triangle-strip vertex generator, Q23.8 coordinates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stroked_rect_strip_gen
    import srsg_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [EDGE_W-1:0]  i_rect_left,
    input  wire logic signed [EDGE_W-1:0]  i_rect_top,
    input  wire logic signed [EDGE_W-1:0]  i_rect_right,
    input  wire logic signed [EDGE_W-1:0]  i_rect_bottom,
    input  wire logic signed [EDGE_W-1:0]  i_stroke_width,
    input  wire logic [WIDTH_W-1:0]        i_min_stroke_width,
    input  wire logic                      i_scale_valid,
    input  wire logic                      i_join_style,
    input  wire logic [LIMIT_W-1:0]        i_miter_limit,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [EDGE_W-1:0]       o_vertex_x,
    output logic signed [EDGE_W-1:0]       o_vertex_y,
    output logic [VNUM_W-1:0]              o_vertex_number,
    output logic                           o_last_vertex
);

    logic  w_push;
    t_desc w_push_desc;
    logic  w_q_ready;
    logic  w_q_valid;
    t_desc w_q_desc;
    logic  w_q_pop;

    srsg_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_rect_left        (i_rect_left),
        .i_rect_top         (i_rect_top),
        .i_rect_right       (i_rect_right),
        .i_rect_bottom      (i_rect_bottom),
        .i_stroke_width     (i_stroke_width),
        .i_min_stroke_width (i_min_stroke_width),
        .i_scale_valid      (i_scale_valid),
        .i_join_style       (i_join_style),
        .i_miter_limit      (i_miter_limit),
        .o_push             (w_push),
        .o_desc             (w_push_desc),
        .i_q_ready          (w_q_ready)
    );

    srsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc),
        .i_pop   (w_q_pop)
    );

    srsg_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_desc        (w_q_desc),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vertex_x      (o_vertex_x),
        .o_vertex_y      (o_vertex_y),
        .o_vertex_number (o_vertex_number),
        .o_last_vertex   (o_last_vertex)
    );

endmodule
`default_nettype wire

/* sv/stroked_rect_strip_gen_checker.sv */
// ---------------------------------------------------------------------------
// stroked_rect_strip_gen_checker
// Port-level checks on the vertex stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stroked_rect_strip_gen_macros.svh"
module stroked_rect_strip_gen_checker
    import srsg_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic signed [EDGE_W-1:0]  o_vertex_x,
    input wire logic signed [EDGE_W-1:0]  o_vertex_y,
    input wire logic [VNUM_W-1:0]         o_vertex_number,
    input wire logic                      o_last_vertex
);

    `SRSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_vertex_x) && $stable(o_vertex_y) && $stable(o_vertex_number) && $stable(o_last_vertex))
    `SRSG_ASSERT_NEXT(a_strip_continues, i_clk, i_rst_n, o_valid && i_ready && !o_last_vertex, o_valid && (o_vertex_number == $past(o_vertex_number) + VNUM_W'(1)))
    `SRSG_ASSERT_NEXT(a_strip_restarts, i_clk, i_rst_n, o_valid && i_ready && o_last_vertex, !o_valid || (o_vertex_number == '0))
    `SRSG_ASSERT_IMPLY(a_strip_length, i_clk, i_rst_n, o_valid && o_last_vertex, (o_vertex_number == LAST_MITER_FILL) || (o_vertex_number == LAST_MITER_HOLL) || (o_vertex_number == LAST_BEVEL_FILL) || (o_vertex_number == LAST_BEVEL_HOLL))

endmodule

bind stroked_rect_strip_gen stroked_rect_strip_gen_checker u_checker (.*);
`default_nettype wire

/* tb/sv/stroked_rect_strip_gen_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stroked_rect_strip_gen_tb
// Drives stroked rectangles through the strip generator with random gaps on
// the input and random stalls on the vertex output. A directed table covers
// the join, fill and saturation corners; random rectangles follow. Every
// vertex is checked in order against a behavioral strip expander.
// ---------------------------------------------------------------------------
module stroked_rect_strip_gen_tb
    import srsg_pkg::*;
();

    localparam int COORD_W         = 32;
    localparam int NUM_RAND_STRIPS = 447;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_WAIT        = 11;

    localparam int MITER_FILL_AT = 0;
    localparam int MITER_HOLL_AT = 4;
    localparam int BEVEL_FILL_AT = 14;
    localparam int BEVEL_HOLL_AT = 22;
    localparam int MITER_FILL_N  = 4;
    localparam int MITER_HOLL_N  = 10;
    localparam int BEVEL_FILL_N  = 8;
    localparam int BEVEL_HOLL_N  = 17;

    localparam logic signed [EDGE_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [EDGE_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic [WIDTH_W-1:0]       MIN_W_MAX = 31'h7fff_ffff;

    typedef struct {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic signed [EDGE_W-1:0] stroke;
        logic [WIDTH_W-1:0]       min_w;
        logic                     scale_ok;
        logic                     join_sel;
        logic [LIMIT_W-1:0]       limit;
    } t_rect_item;

    typedef struct {
        logic signed [EDGE_W-1:0] x;
        logic signed [EDGE_W-1:0] y;
        logic [VNUM_W-1:0]        num;
        logic                     last;
    } t_vertex;

    typedef struct {
        t_rect_item               it;
        int                       want_n;
        logic signed [EDGE_W-1:0] want_x;
        logic signed [EDGE_W-1:0] want_y;
    } t_strip_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [EDGE_W-1:0]  i_rect_left;
    logic signed [EDGE_W-1:0]  i_rect_top;
    logic signed [EDGE_W-1:0]  i_rect_right;
    logic signed [EDGE_W-1:0]  i_rect_bottom;
    logic signed [EDGE_W-1:0]  i_stroke_width;
    logic [WIDTH_W-1:0]        i_min_stroke_width;
    logic                      i_scale_valid;
    logic                      i_join_style;
    logic [LIMIT_W-1:0]        i_miter_limit;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [EDGE_W-1:0]  o_vertex_x;
    logic signed [EDGE_W-1:0]  o_vertex_y;
    logic [VNUM_W-1:0]         o_vertex_number;
    logic                      o_last_vertex;

    t_vertex    vert_q[$];
    t_strip_row strip_rows[$];
    int         mismatch_count;
    int         send_calm;
    int         sink_calm;

    stroked_rect_strip_gen #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rect_left(i_rect_left),
        .i_rect_top(i_rect_top),
        .i_rect_right(i_rect_right),
        .i_rect_bottom(i_rect_bottom),
        .i_stroke_width(i_stroke_width),
        .i_min_stroke_width(i_min_stroke_width),
        .i_scale_valid(i_scale_valid),
        .i_join_style(i_join_style),
        .i_miter_limit(i_miter_limit),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_vertex_x(o_vertex_x),
        .o_vertex_y(o_vertex_y),
        .o_vertex_number(o_vertex_number),
        .o_last_vertex(o_last_vertex)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [5:0] strip_entry(int idx);
        case (idx)
            0, 4, 12:         strip_entry = {SEL_LM, SEL_LM};
            1, 6:             strip_entry = {SEL_HP, SEL_LM};
            2, 10:            strip_entry = {SEL_LM, SEL_HP};
            3, 8:             strip_entry = {SEL_HP, SEL_HP};
            5, 13, 23, 37:    strip_entry = {SEL_LP, SEL_LP};
            7, 25, 27:        strip_entry = {SEL_HM, SEL_LP};
            9, 29, 31:        strip_entry = {SEL_HM, SEL_HM};
            11, 33, 35:       strip_entry = {SEL_LP, SEL_HM};
            14, 24:           strip_entry = {SEL_L,  SEL_LM};
            15, 26:           strip_entry = {SEL_H,  SEL_LM};
            16, 22, 38:       strip_entry = {SEL_LM, SEL_L };
            17, 28:           strip_entry = {SEL_HP, SEL_L };
            18, 36:           strip_entry = {SEL_LM, SEL_H };
            19, 30:           strip_entry = {SEL_HP, SEL_H };
            20, 34:           strip_entry = {SEL_L,  SEL_HP};
            default:          strip_entry = {SEL_H,  SEL_HP};
        endcase
    endfunction

    function automatic logic signed [EDGE_W-1:0] edge_offset(logic [2:0] code, longint lo,
                                                             longint hi, longint half);
        longint ceil_v;
        longint v;
        ceil_v = (longint'(1) <<< (COORD_W - 1)) - 1;
        v = (code < SEL_HM) ? lo : hi;
        case (code)
            SEL_LM, SEL_HM: v = v - half;
            SEL_LP, SEL_HP: v = v + half;
            default: ;
        endcase
        if (v > ceil_v)
            v = ceil_v;
        else if (v < -ceil_v - 1)
            v = -ceil_v - 1;
        return v[EDGE_W-1:0];
    endfunction

    function automatic int expand_strip(t_rect_item it);
        longint  l, t, r, b, w, half, min_dim;
        logic    bevel, filled;
        logic [5:0] sel;
        int      first, n;
        t_vertex v;
        l = longint'(it.left);
        t = longint'(it.top);
        r = longint'(it.right);
        b = longint'(it.bottom);
        if (it.stroke < 0 || !it.scale_ok)
            return 0;
        bevel = (it.join_sel == JOIN_BEVEL) || (it.limit < SQRT2_Q8);
        w = (longint'(it.stroke) > longint'(it.min_w)) ? longint'(it.stroke)
                                                       : longint'(it.min_w);
        half = w >>> 1;
        min_dim = ((r - l) < (b - t)) ? (r - l) : (b - t);
        filled = (w >= min_dim);
        if (!bevel) begin
            first = filled ? MITER_FILL_AT : MITER_HOLL_AT;
            n     = filled ? MITER_FILL_N : MITER_HOLL_N;
        end else begin
            first = filled ? BEVEL_FILL_AT : BEVEL_HOLL_AT;
            n     = filled ? BEVEL_FILL_N : BEVEL_HOLL_N;
        end
        for (int k = 0; k < n; k++) begin
            sel = strip_entry(first + k);
            v.x = edge_offset(sel[5:3], l, r, half);
            v.y = edge_offset(sel[2:0], t, b, half);
            v.num = VNUM_W'(k);
            v.last = (k == n - 1);
            vert_q.push_back(v);
        end
        return n;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(15, 60);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic add_row(input logic signed [EDGE_W-1:0] l, t, r, b, sw,
                           input logic [WIDTH_W-1:0] mw, input logic sv, js,
                           input logic [LIMIT_W-1:0] ml, input int wn,
                           input logic signed [EDGE_W-1:0] wx, wy);
        t_strip_row row;
        row.it = '{l, t, r, b, sw, mw, sv, js, ml};
        row.want_n = wn;
        row.want_x = wx;
        row.want_y = wy;
        strip_rows.push_back(row);
    endtask

    task automatic send_rect(input t_rect_item it, input int want_n,
                             input logic signed [EDGE_W-1:0] want_x, want_y,
                             output int n);
        int gap;
        int base;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_rect_left        <= it.left;
        i_rect_top         <= it.top;
        i_rect_right       <= it.right;
        i_rect_bottom      <= it.bottom;
        i_stroke_width     <= it.stroke;
        i_min_stroke_width <= it.min_w;
        i_scale_valid      <= it.scale_ok;
        i_join_style       <= it.join_sel;
        i_miter_limit      <= it.limit;
        do @(posedge i_clk); while (!o_ready);
        base = vert_q.size();
        n = expand_strip(it);
        if (want_n >= 0 && (n != want_n ||
                (n > 0 && (vert_q[base].x != want_x || vert_q[base].y != want_y)))) begin
            $display("%0t: strip expected %0d vertices from (%0d, %0d), predicted %0d",
                     $time, want_n, want_x, want_y, n);
            mismatch_count++;
        end
    endtask

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("stroked_rect_strip_gen regression: fail");
        $finish;
    end

    initial begin : vertex_sink
        int      gap;
        t_vertex want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(sink_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (vert_q.size() == 0) begin
                $display("%0t: vertex with none expected: x %0d y %0d num %0d last %0b",
                         $time, o_vertex_x, o_vertex_y, o_vertex_number, o_last_vertex);
                mismatch_count++;
            end else begin
                want = vert_q.pop_front();
                if (o_vertex_x !== want.x || o_vertex_y !== want.y ||
                        o_vertex_number !== want.num || o_last_vertex !== want.last) begin
                    $display("%0t: expected x %0d y %0d num %0d last %0b, got x %0d y %0d num %0d last %0b",
                             $time, want.x, want.y, want.num, want.last,
                             o_vertex_x, o_vertex_y, o_vertex_number, o_last_vertex);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_rect_item               it;
        int                       n;
        int                       strips;
        logic signed [EDGE_W-1:0] anchor;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_ready            = 1'b0;
        i_rect_left        = '0;
        i_rect_top         = '0;
        i_rect_right       = '0;
        i_rect_bottom      = '0;
        i_stroke_width     = '0;
        i_min_stroke_width = '0;
        i_scale_valid      = 1'b0;
        i_join_style       = JOIN_MITER;
        i_miter_limit      = '0;
        mismatch_count     = 0;
        send_calm          = 0;
        sink_calm          = 0;

        // left, top, right, bottom, stroke, min, scale, join, limit, count, first x, y
        add_row(0, 0, 0, 0, -256, 0, 1, JOIN_MITER, 16'hffff, 0, 0, 0);
        add_row(0, 0, 0, 0, S32_MIN, 0, 1, JOIN_BEVEL, 16'hffff, 0, 0, 0);
        add_row(0, 0, 0, 0, 512, 0, 0, JOIN_MITER, 16'hffff, 0, 0, 0);
        add_row(0, 0, 0, 0, -1, MIN_W_MAX, 0, JOIN_BEVEL, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 512, 0, 1, JOIN_MITER, SQRT2_Q8, 4, -256, -256);
        add_row(0, 0, 0, 0, 512, 0, 1, JOIN_BEVEL, 16'hffff, 8, 0, -256);
        add_row(0, 0, 0, 0, 512, 0, 1, JOIN_MITER, SQRT2_Q8 - 1, 8, 0, -256);
        add_row(0, 0, 2560, 2560, 512, 0, 1, JOIN_MITER, 16'hffff, 10, -256, -256);
        add_row(0, 0, 2560, 2560, 512, 0, 1, JOIN_BEVEL, 16'hffff, 17, -256, 0);
        add_row(S32_MIN, S32_MIN, S32_MIN + 256, S32_MIN + 256, 32'sh7fff_fffe, 0, 1,
                JOIN_MITER, 16'hffff, 4, S32_MIN, S32_MIN);
        add_row(S32_MAX, S32_MAX, S32_MAX, S32_MAX, 32'sh7fff_fffe, 0, 1,
                JOIN_MITER, 16'hffff, 4, 32'sh4000_0000, 32'sh4000_0000);
        add_row(0, 0, 0, 0, 0, 0, 1, JOIN_MITER, 16'hffff, -1, 0, 0);
        add_row(0, 0, 2560, 2560, 2560, 0, 1, JOIN_MITER, 16'hffff, -1, 0, 0);
        add_row(0, 0, 2560, 2560, 2559, 0, 1, JOIN_BEVEL, 16'hffff, -1, 0, 0);
        add_row(0, 0, 2560, 1280, 3, 0, 1, JOIN_MITER, 16'hffff, -1, 0, 0);
        add_row(2560, 0, 0, 2560, 512, 0, 1, JOIN_BEVEL, 16'hffff, -1, 0, 0);
        add_row(0, 2560, 2560, 0, 512, 0, 1, JOIN_MITER, 16'hffff, -1, 0, 0);
        add_row(-1024, -1024, 1024, 1024, 0, 700, 1, JOIN_MITER, 0, -1, 0, 0);
        add_row(-2560, 256, 2560, 5120, 100, 900, 1, JOIN_BEVEL, 0, -1, 0, 0);
        add_row(S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, MIN_W_MAX, 1,
                JOIN_BEVEL, 16'hffff, -1, 0, 0);
        add_row(S32_MIN, S32_MIN, S32_MAX, S32_MAX, 0, MIN_W_MAX, 1,
                JOIN_MITER, 16'hffff, -1, 0, 0);
        add_row(S32_MAX, S32_MIN, S32_MIN, S32_MAX, 32'sh0fff_ffff, 0, 1,
                JOIN_BEVEL, 16'h8000, -1, 0, 0);
        add_row(-S32_MAX, -S32_MAX, S32_MAX - 4096, S32_MAX - 4096, 32'sh7fff_0000, 0, 1,
                JOIN_MITER, 16'hffff, -1, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (strip_rows[i])
            send_rect(strip_rows[i].it, strip_rows[i].want_n, strip_rows[i].want_x,
                      strip_rows[i].want_y, n);

        strips = 0;
        while (strips < NUM_RAND_STRIPS) begin
            it.scale_ok = ($urandom_range(0, 15) != 0);
            it.join_sel = 1'($urandom_range(0, 1));
            it.limit = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(355, 371))
                                                   : 16'($urandom);
            it.min_w = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 1024));
            case ($urandom_range(0, 9))
                0: begin
                    it.left     = $urandom;
                    it.top      = $urandom;
                    it.right    = $urandom;
                    it.bottom   = $urandom;
                    it.stroke   = $urandom;
                    it.scale_ok = 1'($urandom_range(0, 1));
                end
                1: begin
                    // park the rectangle against one end of the range
                    anchor = $urandom_range(0, 1) ? S32_MAX - 8192 : S32_MIN;
                    it.left   = anchor + $urandom_range(0, 4096);
                    it.right  = it.left + $urandom_range(0, 4096);
                    it.top    = anchor + $urandom_range(0, 4096);
                    it.bottom = it.top + $urandom_range(0, 4096);
                    it.stroke = $urandom_range(0, 1) ? $urandom_range(0, 32'h7fff_ffff)
                                                     : $urandom_range(0, 8192);
                end
                default: begin
                    it.left   = 32'($urandom_range(0, 2097152)) - 32'sd1048576;
                    it.top    = 32'($urandom_range(0, 2097152)) - 32'sd1048576;
                    it.right  = it.left + $urandom_range(0, 4096) - 256;
                    it.bottom = it.top + $urandom_range(0, 4096) - 256;
                    it.stroke = ($urandom_range(0, 15) == 0) ? -$urandom_range(1, 4096)
                                                             : $urandom_range(0, 4096);
                end
            endcase
            send_rect(it, -1, 0, 0, n);
            strips++;
        end
        i_valid <= 1'b0;

        while (vert_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("stroked_rect_strip_gen regression: pass");
        else
            $display("stroked_rect_strip_gen regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/srsg_pkg.sv
sv/srsg_front.sv
sv/srsg_queue.sv
sv/srsg_back.sv
sv/stroked_rect_strip_gen.sv
sv/stroked_rect_strip_gen_checker.sv
tb/sv/stroked_rect_strip_gen_tb.sv
